FILE: rtl/tcs_pkg.sv
// Package for the timestamped counting semaphore.
// Holds operation codes, status codes and the sequencer state type.
// No dependencies.
package tcs_pkg;

  // Operation codes carried on the kind port
  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_TAKE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_TAKE
  } state_t;

endpackage

FILE: rtl/timestamped_counting_semaphore_top.sv
// Timestamped counting semaphore: top level with sequencer and count/head state.
// Depends on tcs_pkg and tcs_ram.
//
// Usage:
//   Drive kind, amount and now_stamp and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. Exactly one result
//   follows: done is high for one cycle with status, oldest_stamp and level.
//   The receiver cannot hold a result off; it must take it in that cycle.
// Timing:
//   Set or add of n units (n > 0, no overflow): the stamp ring is written one
//   entry per cycle through the RAM write port while busy is high, and done
//   rises as the last entry is written.
//   Take of a held unit: one RAM read with registered data, which is registered
//   into oldest_stamp together with done at the end of S_TAKE; busy is high in S_TAKE.
//   Rejected, empty, zero-amount and unused operations: done follows in the
//   next cycle, busy stays low, so such transactions may come every cycle.
// Reset:
//   rst empties the semaphore (level zero, ring restarts at entry zero) and
//   drops any transaction in flight. The stamp RAM is not cleared; only
//   entries written since are ever read.
module timestamped_counting_semaphore_top
  import tcs_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  amount,
  input  logic [31:0] now_stamp,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] oldest_stamp,
  output logic [5:0]  level
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [8:0] CAP9 = 9'(CAPACITY);
  localparam logic [IW-1:0] LAST_POS = IW'(CAPACITY - 1);

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [IW-1:0]    head, head_next;
  logic [IW-1:0]    wr_ptr, wr_ptr_next;
  logic [CW-1:0]    remaining, remaining_next;
  logic [STAMP_BITS-1:0] stamp_hold, stamp_hold_next;
  logic             done_next;
  logic [1:0]       status_next;
  logic [31:0]      oldest_stamp_next;

  logic             accept;
  logic             rd_en;
  logic [STAMP_BITS-1:0] rdata;
  logic [63:0]      stamp_wide;
  logic [63:0]      rdata_wide;
  logic [8:0]       add_sum;
  logic [8:0]       tail_sum;
  logic [IW-1:0]    tail_pos;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign level      = 6'(count);
  assign stamp_wide = {32'd0, now_stamp};
  assign rdata_wide = 64'(rdata);

  // Overflow check for add and ring position just past the newest unit
  assign add_sum  = 9'(count) + 9'(amount);
  assign tail_sum = 9'(head) + 9'(count);
  assign tail_pos = (tail_sum >= CAP9) ? IW'(tail_sum - CAP9) : IW'(tail_sum);

  // Read the oldest entry as a take transaction is accepted
  assign rd_en = accept && (kind == KIND_TAKE) && (count != '0);

  tcs_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (state == S_FILL),
    .waddr (wr_ptr),
    .wdata (stamp_hold),
    .re    (rd_en),
    .raddr (head),
    .rdata (rdata)
  );

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      remaining <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      remaining <= remaining_next;
      done      <= done_next;
    end
    wr_ptr       <= wr_ptr_next;
    stamp_hold   <= stamp_hold_next;
    status       <= status_next;
    oldest_stamp <= oldest_stamp_next;
  end

  // Sequence operations: decide at accept, fill one entry per cycle, finish take
  always_comb begin
    state_next        = state;
    count_next        = count;
    head_next         = head;
    wr_ptr_next       = wr_ptr;
    remaining_next    = remaining;
    stamp_hold_next   = stamp_hold;
    done_next         = 1'b0;
    status_next       = status;
    oldest_stamp_next = oldest_stamp;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          stamp_hold_next   = stamp_wide[STAMP_BITS-1:0];
          oldest_stamp_next = '0;
          status_next       = ST_OK;
          unique case (kind_t'(kind))
            KIND_SET: begin
              if (9'(amount) > CAP9) begin
                status_next = ST_OVERFLOW;
                done_next   = 1'b1;
              end else begin
                head_next      = '0;
                count_next     = CW'(amount);
                wr_ptr_next    = '0;
                remaining_next = CW'(amount);
                if (amount == 8'd0) begin
                  done_next = 1'b1;
                end else begin
                  state_next = S_FILL;
                end
              end
            end
            KIND_ADD: begin
              if (add_sum > CAP9) begin
                status_next = ST_OVERFLOW;
                done_next   = 1'b1;
              end else begin
                count_next     = CW'(add_sum);
                wr_ptr_next    = tail_pos;
                remaining_next = CW'(amount);
                if (amount == 8'd0) begin
                  done_next = 1'b1;
                end else begin
                  state_next = S_FILL;
                end
              end
            end
            KIND_TAKE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                head_next  = (head == LAST_POS) ? '0 : head + 1'b1;
                count_next = count - 1'b1;
                state_next = S_TAKE;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        wr_ptr_next    = (wr_ptr == LAST_POS) ? '0 : wr_ptr + 1'b1;
        remaining_next = remaining - 1'b1;
        if (remaining == CW'(1)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TAKE: begin
        oldest_stamp_next = rdata_wide[31:0];
        done_next         = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Level never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    9'(count) <= CAP9)
    else $error("unit count above capacity");

  // An empty or rejected result never carries a stamp
  a_stamp_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY || status == ST_OVERFLOW) |-> oldest_stamp == 32'd0)
    else $error("stamp returned with a failing status");

  // The fill loop never runs with nothing left to write
  a_fill_live: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> remaining != '0)
    else $error("fill state with zero entries left");

  // A take state is followed in the next cycle by the idle state with done
  a_take_len: assert property (@(posedge clk) disable iff (rst)
    state == S_TAKE |=> state == S_IDLE && done)
    else $error("take did not finish in one cycle");

endmodule

FILE: rtl/tcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the stamp ring of the semaphore. No dependencies.
module tcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: bench/timestamped_counting_semaphore_top_tb.sv
// Testbench for timestamped_counting_semaphore_top: set, add and take transactions
// checked result by result against an in-bench semaphore predictor.
// Depends on tcs_pkg and the RTL of the semaphore.
module timestamped_counting_semaphore_top_tb
  import tcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_BLOCKS = 27;
  localparam int BLOCK_LEN   = 50;

  typedef struct {
    kind_t       op;
    logic [7:0]  count;
    logic [31:0] stamp;
    int          gap;
    bit          drain;
  } sem_op_t;

  typedef struct {
    status_t     status;
    logic [31:0] stamp;
    logic [5:0]  level;
  } sem_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_NONE;
  logic [7:0]  amount = '0;
  logic [31:0] now_stamp = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] oldest_stamp;
  logic [5:0]  level;

  sem_op_t     pending_ops[$];
  sem_result_t expected_results[$];

  // Predictor state: stamp ring, head position and unit count
  logic [31:0] stamp_ring[CAP];
  int          ring_head = 0;
  int          units_held = 0;

  bit took = 1'b0;
  bit burst = 1'b0;
  int idle_left = 0;
  int errors = 0;
  int quiet_cycles = 0;

  timestamped_counting_semaphore_top #(
    .CAPACITY  (CAP),
    .STAMP_BITS(32)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .amount      (amount),
    .now_stamp   (now_stamp),
    .done        (done),
    .status      (status),
    .oldest_stamp(oldest_stamp),
    .level       (level)
  );

  always #5 clk = ~clk;

  // Apply one operation to the predicted semaphore and return its result
  function automatic sem_result_t apply_semaphore_op(kind_t op, logic [7:0] n,
                                                     logic [31:0] stamp);
    sem_result_t r;
    int          i;
    r.status = ST_OK;
    r.stamp  = '0;
    case (op)
      KIND_SET: begin
        if (n > CAP) begin
          r.status = ST_OVERFLOW;
        end else begin
          ring_head  = 0;
          units_held = n;
          for (i = 0; i < n; i++) stamp_ring[i] = stamp;
        end
      end
      KIND_ADD: begin
        if (units_held + n > CAP) begin
          r.status = ST_OVERFLOW;
        end else begin
          for (i = 0; i < n; i++) stamp_ring[(ring_head + units_held + i) % CAP] = stamp;
          units_held += n;
        end
      end
      KIND_TAKE: begin
        if (units_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.stamp    = stamp_ring[ring_head];
          ring_head  = (ring_head + 1) % CAP;
          units_held -= 1;
        end
      end
      default: ;
    endcase
    r.level = units_held[5:0];
    return r;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Queue one operation with its lead-in gap
  task automatic queue_op(kind_t op, int n, logic [31:0] stamp, bit drain);
    sem_op_t t;
    t.op    = op;
    t.count = n[7:0];
    t.stamp = stamp;
    t.gap   = burst ? 0 : $urandom_range(0, 4);
    t.drain = drain;
    pending_ops.push_back(t);
  endtask

  // Drive transactions at the falling edge; hold start until accepted
  always @(negedge clk) begin
    sem_op_t t;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].drain && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        t = pending_ops.pop_front();
        kind      <= t.op;
        amount    <= t.count;
        now_stamp <= t.stamp;
        start     <= 1'b1;
        if (pending_ops.size() != 0) idle_left = pending_ops[0].gap;
      end
    end
  end

  // Check results, record accepted transactions, watch for a stall
  always @(posedge clk) begin
    sem_result_t want;
    if (rst) begin
      took = 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with none pending: status %0d stamp %h level %0d",
                               status, oldest_stamp, level));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || oldest_stamp !== want.stamp ||
              level !== want.level)
            flag_error($sformatf("expected status %0d stamp %h level %0d, got %0d %h %0d",
                                 want.status, want.stamp, want.level,
                                 status, oldest_stamp, level));
        end
      end
      took = start && !busy;
      if (took)
        expected_results.push_back(apply_semaphore_op(kind_t'(kind), amount, now_stamp));
      if (took || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int    blk;
    int    k;
    int    r;
    int    regime;
    kind_t any_post;
    // Directed: empty take, full set, wrap, overflow, zero amounts, unused kind
    queue_op(KIND_TAKE, 255, 32'h0000_0000, 1'b0);
    queue_op(KIND_SET,  0,   32'h1234_5678, 1'b0);
    queue_op(KIND_SET,  32,  32'hFFFF_FFFF, 1'b0);
    queue_op(KIND_ADD,  1,   32'h0000_0001, 1'b0);
    queue_op(KIND_TAKE, 0,   32'h0000_0000, 1'b0);
    queue_op(KIND_ADD,  1,   32'h0000_0000, 1'b0);
    queue_op(KIND_TAKE, 0,   32'hFFFF_FFFF, 1'b0);
    queue_op(KIND_SET,  33,  32'hAAAA_AAAA, 1'b0);
    queue_op(KIND_SET,  255, 32'h5555_5555, 1'b0);
    queue_op(KIND_NONE, 255, 32'hFFFF_FFFF, 1'b0);
    queue_op(KIND_SET,  5,   32'hA5A5_0001, 1'b1);
    queue_op(KIND_ADD,  3,   32'h5A5A_0002, 1'b0);
    queue_op(KIND_ADD,  25,  32'h0F0F_0003, 1'b0);
    queue_op(KIND_ADD,  24,  32'hF0F0_0004, 1'b0);
    queue_op(KIND_TAKE, 7,   32'h0000_0000, 1'b0);
    queue_op(KIND_TAKE, 0,   32'h0000_0000, 1'b0);
    queue_op(KIND_ADD,  0,   32'hDEAD_0005, 1'b0);
    queue_op(KIND_ADD,  255, 32'hDEAD_0006, 1'b0);
    queue_op(KIND_TAKE, 0,   32'h0000_0000, 1'b0);
    queue_op(KIND_SET,  0,   32'h0000_0000, 1'b0);
    queue_op(KIND_TAKE, 0,   32'h0000_0000, 1'b0);
    queue_op(KIND_NONE, 0,   32'h0000_0000, 1'b0);

    // Random: blocks that lean toward filling, draining or a mix
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      regime = $urandom_range(0, 2);
      burst  = ($urandom_range(0, 3) == 0);
      for (k = 0; k < BLOCK_LEN; k++) begin
        r = $urandom_range(0, 99);
        any_post = $urandom_range(0, 1) ? KIND_SET : KIND_ADD;
        if (k == 0 && (blk == 0 || $urandom_range(0, 3) == 0)) begin
          queue_op(KIND_TAKE, $urandom_range(0, 255), $urandom(), 1'b1);
        end else if (regime == 0) begin
          if (r < 60)      queue_op(KIND_ADD, $urandom_range(1, 6), $urandom(), 1'b0);
          else if (r < 70) queue_op(KIND_SET, $urandom_range(0, 32), $urandom(), 1'b0);
          else if (r < 90) queue_op(KIND_TAKE, $urandom_range(0, 255), $urandom(), 1'b0);
          else if (r < 95) queue_op(any_post, $urandom_range(0, 255), $urandom(), 1'b0);
          else             queue_op(KIND_NONE, $urandom_range(0, 255), $urandom(), 1'b0);
        end else if (regime == 1) begin
          if (r < 15)      queue_op(KIND_ADD, $urandom_range(0, 3), $urandom(), 1'b0);
          else if (r < 80) queue_op(KIND_TAKE, $urandom_range(0, 255), $urandom(), 1'b0);
          else if (r < 85) queue_op(KIND_SET, $urandom_range(0, 8), $urandom(), 1'b0);
          else if (r < 95) queue_op(any_post, $urandom_range(0, 255), $urandom(), 1'b0);
          else             queue_op(KIND_NONE, $urandom_range(0, 255), $urandom(), 1'b0);
        end else begin
          if (r < 35)      queue_op(KIND_ADD, $urandom_range(0, 4), $urandom(), 1'b0);
          else if (r < 75) queue_op(KIND_TAKE, $urandom_range(0, 255), $urandom(), 1'b0);
          else if (r < 83) queue_op(KIND_SET, $urandom_range(0, 32), $urandom(), 1'b0);
          else if (r < 93) queue_op(any_post, $urandom_range(0, 255), $urandom(), 1'b0);
          else             queue_op(KIND_NONE, $urandom_range(0, 255), $urandom(), 1'b0);
        end
      end
    end

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for the last transaction, then for its result, then let the block settle
    while (pending_ops.size() != 0 || start) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
